// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

// ----- hdl/jbhe_pkg.sv -----
package jbhe_pkg;

  localparam int NUM_TABLES     = 4;
  localparam int NUM_COMPONENTS = 4;

  localparam int DC_SYMS  = 16;
  localparam int AC_SYMS  = 256;
  localparam int DC_DEPTH = NUM_TABLES * DC_SYMS;
  localparam int AC_DEPTH = NUM_TABLES * AC_SYMS;
  localparam int DC_AW    = $clog2(DC_DEPTH);
  localparam int AC_AW    = $clog2(AC_DEPTH);
  localparam int TBL_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int COMP_W   = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  localparam logic [7:0] ZRL_SYM = 8'hF0;
  localparam logic [7:0] EOB_SYM = 8'h00;
  localparam int RUN_LEN      = 16;
  localparam int MAX_CODE_LEN = 16;
  localparam int POS_LAST     = 63;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOAD_DC = 2'd0,
    ACT_LOAD_AC = 2'd1,
    ACT_COEF    = 2'd2,
    ACT_RESTART = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    OP_LOAD_DC = 2'd0,
    OP_LOAD_AC = 2'd1,
    OP_DC      = 2'd2,
    OP_AC      = 2'd3
  } op_t;

  typedef struct packed {
    act_t               action;
    logic [1:0]         table_number;
    logic [7:0]         table_symbol;
    logic [4:0]         code_length;
    logic [15:0]        code_word;
    logic [1:0]         component;
    logic [1:0]         dc_sel;
    logic [1:0]         ac_sel;
    logic [5:0]         position;
    logic signed [11:0] coefficient;
  } in_word_t;

  typedef struct packed {
    logic [27:0] bits;
    logic [4:0]  bit_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] code;
  } tbl_entry_t;

  typedef struct packed {
    op_t              op;
    logic [TBL_W-1:0] tbl;
    logic [7:0]       sym;
    tbl_entry_t       entry;
    logic [11:0]      vb;
    logic [3:0]       size;
    logic [1:0]       zrl;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic logic [TBL_W-1:0] sat_tbl(input logic [1:0] v);
    logic [TBL_W-1:0] r;
    if (32'(v) >= NUM_TABLES) begin
      r = TBL_W'(NUM_TABLES - 1);
    end else begin
      r = TBL_W'(v);
    end
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] sat_comp(input logic [1:0] v);
    logic [COMP_W-1:0] r;
    if (32'(v) >= NUM_COMPONENTS) begin
      r = COMP_W'(NUM_COMPONENTS - 1);
    end else begin
      r = COMP_W'(v);
    end
    return r;
  endfunction

  function automatic logic [3:0] mag_size(input logic [11:0] m);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (m[i]) begin
        s = 4'(i + 1);
      end
    end
    return s;
  endfunction

  function automatic logic [11:0] mag_bits(input logic neg, input logic [11:0] m,
                                           input logic [3:0] s);
    logic [12:0] mask;
    mask = (13'd1 << s) - 13'd1;
    return neg ? (~m & mask[11:0]) : m;
  endfunction

endpackage

// ----- hdl/jbhe_front.sv -----
module jbhe_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  jbhe_pkg::in_word_t in_data,
  output logic               push,
  output jbhe_pkg::cmd_t     cmd
);

  logic signed [11:0] pred_r   [jbhe_pkg::NUM_COMPONENTS];
  logic signed [11:0] pred_nxt [jbhe_pkg::NUM_COMPONENTS];
  logic [5:0]         zrun_r, zrun_nxt;

  logic [jbhe_pkg::COMP_W-1:0] comp;
  logic [jbhe_pkg::TBL_W-1:0]  ltbl, dtbl, atbl;
  logic signed [12:0]          diff;
  logic [11:0]                 dc_abs, ac_abs;
  logic [3:0]                  dc_size, ac_size;
  logic [11:0]                 dc_vb, ac_vb;
  logic [4:0]                  load_len;
  logic signed [12:0]          coef13;

  always_comb begin
    comp     = jbhe_pkg::sat_comp(in_data.component);
    ltbl     = jbhe_pkg::sat_tbl(in_data.table_number);
    dtbl     = jbhe_pkg::sat_tbl(in_data.dc_sel);
    atbl     = jbhe_pkg::sat_tbl(in_data.ac_sel);
    coef13   = 13'(in_data.coefficient);
    diff     = coef13 - 13'(pred_r[comp]);
    dc_abs   = diff[12] ? 12'(-diff) : diff[11:0];
    dc_size  = jbhe_pkg::mag_size(dc_abs);
    dc_vb    = jbhe_pkg::mag_bits(diff[12], dc_abs, dc_size);
    ac_abs   = coef13[12] ? 12'(-coef13) : coef13[11:0];
    ac_size  = jbhe_pkg::mag_size(ac_abs);
    ac_vb    = jbhe_pkg::mag_bits(coef13[12], ac_abs, ac_size);
    load_len = (32'(in_data.code_length) > jbhe_pkg::MAX_CODE_LEN) ?
               5'(jbhe_pkg::MAX_CODE_LEN) : in_data.code_length;
  end

  always_comb begin
    push     = 1'b0;
    cmd      = '0;
    pred_nxt = pred_r;
    zrun_nxt = zrun_r;
    if (accept) begin
      case (in_data.action)
        jbhe_pkg::ACT_LOAD_DC: begin
          if (32'(in_data.table_symbol) < jbhe_pkg::DC_SYMS) begin
            push       = 1'b1;
            cmd.op     = jbhe_pkg::OP_LOAD_DC;
            cmd.tbl    = ltbl;
            cmd.sym    = in_data.table_symbol;
            cmd.entry  = '{len: load_len, code: in_data.code_word};
          end
        end
        jbhe_pkg::ACT_LOAD_AC: begin
          push       = 1'b1;
          cmd.op     = jbhe_pkg::OP_LOAD_AC;
          cmd.tbl    = ltbl;
          cmd.sym    = in_data.table_symbol;
          cmd.entry  = '{len: load_len, code: in_data.code_word};
        end
        jbhe_pkg::ACT_RESTART: begin
          for (int i = 0; i < jbhe_pkg::NUM_COMPONENTS; i++) begin
            pred_nxt[i] = '0;
          end
        end
        jbhe_pkg::ACT_COEF: begin
          if (in_data.position == '0) begin
            push           = 1'b1;
            cmd.op         = jbhe_pkg::OP_DC;
            cmd.tbl        = dtbl;
            cmd.sym        = {4'd0, dc_size};
            cmd.vb         = dc_vb;
            cmd.size       = dc_size;
            pred_nxt[comp] = in_data.coefficient;
            zrun_nxt       = '0;
          end else if (in_data.coefficient == '0) begin
            if (in_data.position == 6'(jbhe_pkg::POS_LAST)) begin
              push     = 1'b1;
              cmd.op   = jbhe_pkg::OP_AC;
              cmd.tbl  = atbl;
              cmd.sym  = jbhe_pkg::EOB_SYM;
              zrun_nxt = '0;
            end else if (zrun_r != '1) begin
              zrun_nxt = zrun_r + 6'd1;
            end
          end else begin
            push     = 1'b1;
            cmd.op   = jbhe_pkg::OP_AC;
            cmd.tbl  = atbl;
            cmd.sym  = {4'(zrun_r % jbhe_pkg::RUN_LEN), ac_size};
            cmd.vb   = ac_vb;
            cmd.size = ac_size;
            cmd.zrl  = 2'(zrun_r / jbhe_pkg::RUN_LEN);
            zrun_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < jbhe_pkg::NUM_COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
      zrun_r <= '0;
    end else begin
      pred_r <= pred_nxt;
      zrun_r <= zrun_nxt;
    end
  end

endmodule

// ----- hdl/jbhe_queue.sv -----
module jbhe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jbhe_pkg::cmd_t    cmd_in,
  input  logic              pop,
  output jbhe_pkg::cmd_t    head,
  output jbhe_pkg::q_stat_t stat
);

  jbhe_pkg::cmd_t              q_mem_r [jbhe_pkg::QUEUE_DEPTH];
  logic [jbhe_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [jbhe_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [jbhe_pkg::Q_CW-1:0]   count_r, count_nxt;

  function automatic logic [jbhe_pkg::Q_AW-1:0] wrap_inc(input logic [jbhe_pkg::Q_AW-1:0] p);
    return (p == jbhe_pkg::Q_AW'(jbhe_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head       = q_mem_r[rd_ptr_r];
    stat.valid = (count_r != '0);
    stat.full  = (count_r == jbhe_pkg::Q_CW'(jbhe_pkg::QUEUE_DEPTH));
    wr_ptr_nxt = push ? wrap_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? wrap_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/jbhe_back.sv -----
module jbhe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jbhe_pkg::q_stat_t   q_stat,
  input  jbhe_pkg::cmd_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output jbhe_pkg::out_word_t out_data
);

  jbhe_pkg::tbl_entry_t dc_mem [jbhe_pkg::DC_DEPTH];
  jbhe_pkg::tbl_entry_t ac_mem [jbhe_pkg::AC_DEPTH];
  jbhe_pkg::tbl_entry_t dc_rd_r, ac_rd_r;

  logic [1:0]          zrl_done_r, zrl_done_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_dc_r;
  logic [11:0]         s1_vb_r;
  logic [3:0]          s1_size_r;
  logic                s1_last_r;
  logic                out_valid_r, out_valid_nxt;
  jbhe_pkg::out_word_t out_data_r, out_word;

  logic                       head_load, out_free, s1_adv, s1_free;
  logic                       rd_issue, zrl_pending;
  logic                       dc_wr, ac_wr, dc_rd, ac_rd;
  logic [7:0]                 ac_sym;
  logic [jbhe_pkg::DC_AW-1:0] dc_addr;
  logic [jbhe_pkg::AC_AW-1:0] ac_addr;
  jbhe_pkg::tbl_entry_t       ent;
  logic [16:0]                code_mask;
  logic [15:0]                code;

  always_comb begin
    head_load   = (head.op == jbhe_pkg::OP_LOAD_DC) || (head.op == jbhe_pkg::OP_LOAD_AC);
    out_free    = !out_valid_r || !out_stall;
    s1_adv      = s1_valid_r && out_free;
    s1_free     = !s1_valid_r || s1_adv;
    rd_issue    = q_stat.valid && !head_load && s1_free;
    zrl_pending = (head.op == jbhe_pkg::OP_AC) && (zrl_done_r != head.zrl);
    pop         = q_stat.valid && (head_load || (rd_issue && !zrl_pending));
    ac_sym      = zrl_pending ? jbhe_pkg::ZRL_SYM : head.sym;
    dc_addr     = jbhe_pkg::DC_AW'(32'(head.tbl) * jbhe_pkg::DC_SYMS + 32'(head.sym[3:0]));
    ac_addr     = jbhe_pkg::AC_AW'(32'(head.tbl) * jbhe_pkg::AC_SYMS + 32'(ac_sym));
    dc_wr       = q_stat.valid && (head.op == jbhe_pkg::OP_LOAD_DC);
    ac_wr       = q_stat.valid && (head.op == jbhe_pkg::OP_LOAD_AC);
    dc_rd       = rd_issue && (head.op == jbhe_pkg::OP_DC);
    ac_rd       = rd_issue && (head.op == jbhe_pkg::OP_AC);

    zrl_done_nxt = zrl_done_r;
    if (rd_issue && zrl_pending) begin
      zrl_done_nxt = zrl_done_r + 2'd1;
    end else if (pop) begin
      zrl_done_nxt = '0;
    end

    s1_valid_nxt = rd_issue ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

    ent                = s1_dc_r ? dc_rd_r : ac_rd_r;
    code_mask          = (17'd1 << ent.len) - 17'd1;
    code               = ent.code & code_mask[15:0];
    out_word.bits      = (28'(code) << s1_size_r) | 28'(s1_vb_r);
    out_word.bit_count = 5'(6'(ent.len) + 6'(s1_size_r));
    out_word.last      = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (dc_wr) begin
      dc_mem[dc_addr] <= head.entry;
    end
    if (dc_rd) begin
      dc_rd_r <= dc_mem[dc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ac_wr) begin
      ac_mem[ac_addr] <= head.entry;
    end
    if (ac_rd) begin
      ac_rd_r <= ac_mem[ac_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      s1_dc_r   <= (head.op == jbhe_pkg::OP_DC);
      s1_vb_r   <= zrl_pending ? '0 : head.vb;
      s1_size_r <= zrl_pending ? '0 : head.size;
      s1_last_r <= !zrl_pending;
    end
    if (s1_adv) begin
      out_data_r <= out_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zrl_done_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      zrl_done_r  <= zrl_done_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/jpeg_baseline_block_huffman_encoder_unit.sv -----
// Baseline JPEG Huffman coder for 8x8 blocks: takes one word per cycle (table
// load, restart, or a zigzag-ordered coefficient) and emits code-plus-magnitude
// words with a bit count and a last flag; bit packing and stuffing are done
// downstream. The front end keeps the DC predictors and the AC zero-run count
// and takes one word every cycle while the 4-entry command queue has room. The
// back end makes one table lookup per cycle on the DC or AC code memory (one
// port each) unless the output stalls; a coefficient that follows at least 16,
// 32 or 48 zeros first sends one, two or three ZRL codes; a load only writes
// its memory. The first result of a word passes the command queue, the stage-1
// and table read registers and the output register. Code tables are undefined
// until loaded and must be loaded before coefficients that use them.
`include "assert_macros.svh"

module jpeg_baseline_block_huffman_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jbhe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jbhe_pkg::out_word_t out_data
);

  logic              accept;
  logic              q_push, q_pop;
  jbhe_pkg::cmd_t    q_cmd_in, q_head;
  jbhe_pkg::q_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  jbhe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (q_push),
    .cmd     (q_cmd_in)
  );

  jbhe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .cmd_in (q_cmd_in),
    .pop    (q_pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  jbhe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_NOW(a_push_on_accept, clk, rst_n, q_push, in_valid && !in_stall)
  `ASSERT_NOW(a_pop_has_data, clk, rst_n, q_pop, q_stat.valid)
  `ASSERT_NEXT(a_full_holds, clk, rst_n, q_stat.full && !q_pop, in_stall)

endmodule
